### rtl/graph_partition_vote_and_migrate_macros.svh
// assertion macros for the partition vote and migrate block
`ifndef GRAPH_PARTITION_VOTE_AND_MIGRATE_MACROS_SVH
`define GRAPH_PARTITION_VOTE_AND_MIGRATE_MACROS_SVH

// condition must hold at every edge outside reset
`define GPVM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define GPVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpvm_pkg.sv
`timescale 1ns / 1ps
package gpvm_pkg;

  localparam int PART_W       = 4;
  localparam int NUM_PARTS    = 1 << PART_W;
  localparam int PAIR_W       = 2 * PART_W;
  localparam int PAIR_DEPTH   = NUM_PARTS * NUM_PARTS;
  localparam int MAX_VERTICES = 4096;
  localparam int VID_W        = $clog2(MAX_VERTICES);
  localparam int NUM_W        = 12;
  localparam int CNT_W        = NUM_W + 1;
  localparam int BLOCK_SIZE   = 16;
  localparam int BLK_W        = $clog2(BLOCK_SIZE);
  localparam int ACT_W        = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PART_W-1:0] part_t;
  typedef logic [NUM_W-1:0]  num_t;

  localparam cnt_t CNT_MAX = '1;
  localparam num_t NUM_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_VOTE    = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_FINISH  = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_MIGRATE = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_NEW     = ACT_W'(3);

  typedef struct packed {
    logic latch;
    logic vote;
    logic clear;
    logic scan_init;
    logic scan_step;
    logic fin_rd;
    logic fin_upd;
    logic mig_rda;
    logic mig_rdb;
    logic mig_cmp;
    logic mig_fill;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  function automatic num_t clamp_num(input cnt_t v);
    return v[CNT_W-1] ? NUM_MAX : v[NUM_W-1:0];
  endfunction

endpackage

### rtl/gpvm_ctrl.sv
`timescale 1ns / 1ps
module gpvm_ctrl import gpvm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] action,
  input  ctl_sts_t         sts,
  output logic             in_stall,
  output ctl_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FSTART = 4'd1;
  localparam logic [3:0] S_FSCAN  = 4'd2;
  localparam logic [3:0] S_FRD    = 4'd3;
  localparam logic [3:0] S_FUPD   = 4'd4;
  localparam logic [3:0] S_MRDA   = 4'd5;
  localparam logic [3:0] S_MRDB   = 4'd6;
  localparam logic [3:0] S_MCMP   = 4'd7;
  localparam logic [3:0] S_MFILL  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          case (action)
            ACT_VOTE:    cmd.vote = 1'b1;
            ACT_NEW:     cmd.clear = 1'b1;
            ACT_FINISH:  state_next = S_FSTART;
            ACT_MIGRATE: state_next = S_MRDA;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_FSTART: begin
        cmd.scan_init = 1'b1;
        state_next    = S_FSCAN;
      end
      S_FSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        cmd.fin_rd = 1'b1;
        state_next = S_FUPD;
      end
      S_FUPD: begin
        cmd.fin_upd = 1'b1;
        state_next  = S_EMIT;
      end
      S_MRDA: begin
        cmd.mig_rda = 1'b1;
        state_next  = S_MRDB;
      end
      S_MRDB: begin
        cmd.mig_rdb = 1'b1;
        state_next  = S_MCMP;
      end
      S_MCMP: begin
        cmd.mig_cmp = 1'b1;
        state_next  = S_MFILL;
      end
      S_MFILL: begin
        cmd.mig_fill = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/gpvm_dp.sv
`timescale 1ns / 1ps
module gpvm_dp import gpvm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         cmd,
  input  part_t            home_part,
  input  part_t            neighbor_part,
  input  part_t            proposed_part,
  input  num_t             proposal_num,
  input  logic [VID_W-1:0] vertex_id,
  input  logic             out_stall,
  output ctl_sts_t         sts,
  output logic             out_valid,
  output part_t            target_part,
  output num_t             number,
  output logic             accepted,
  output logic             block_done,
  output logic [VID_W-1:0] vertex_out
);

  cnt_t tally [NUM_PARTS];
  cnt_t fill [NUM_PARTS];
  cnt_t pair_mem [PAIR_DEPTH];
  logic [PAIR_DEPTH-1:0] pair_vld;
  cnt_t pair_q;
  logic pair_qv;

  part_t h;
  part_t prop;
  part_t best;
  num_t  pnum;
  logic [VID_W-1:0] vid;
  part_t scan_idx;
  cnt_t  best_cnt;
  cnt_t  lim_a;
  logic  acc;

  part_t res_target;
  num_t  res_number;
  logic  res_acc;
  logic  res_blk;

  part_t tally_addr;
  cnt_t  tally_rd;
  logic [PAIR_W-1:0] rd_addr;
  logic [PAIR_W-1:0] wr_addr;
  cnt_t  pair_val;
  cnt_t  lim;
  cnt_t  slot;
  cnt_t  slot_inc;
  logic  slot_room;
  logic  blk;

  // single read port on the tally bank
  assign tally_addr = cmd.vote ? neighbor_part : (cmd.scan_init ? h : scan_idx);
  assign tally_rd   = tally[tally_addr];

  assign rd_addr  = cmd.fin_rd ? {h, best} : (cmd.mig_rda ? {h, prop} : {prop, h});
  assign wr_addr  = {h, best};
  assign pair_val = pair_qv ? pair_q : '0;
  assign lim      = (lim_a < pair_val) ? lim_a : pair_val;

  assign slot      = fill[best];
  assign slot_room = (slot != CNT_MAX);
  assign slot_inc  = slot + cnt_t'(1);
  assign blk       = slot_room && (slot_inc[BLK_W-1:0] == '0);

  assign sts.scan_last = (scan_idx == part_t'(NUM_PARTS - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  // item fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      h    <= home_part;
      prop <= proposed_part;
      pnum <= proposal_num;
      vid  <= vertex_id;
    end
  end

  // neighbor tallies
  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.fin_upd) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        tally[i] <= '0;
      end
    end else if (cmd.vote) begin
      tally[tally_addr] <= sat_inc(tally_rd);
    end
  end

  // partition fill counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        fill[i] <= '0;
      end
    end else if (cmd.mig_fill && slot_room) begin
      fill[best] <= slot_inc;
    end
  end

  // pair counter memory, entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (cmd.fin_upd) begin
      pair_mem[wr_addr] <= sat_inc(pair_val);
    end
    pair_q  <= pair_mem[rd_addr];
    pair_qv <= pair_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pair_vld <= '0;
    end else if (cmd.fin_upd) begin
      pair_vld[wr_addr] <= 1'b1;
    end
  end

  // vote scan and migrate decision
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best     <= h;
      best_cnt <= tally_rd;
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      if (tally_rd > best_cnt) begin
        best     <= scan_idx;
        best_cnt <= tally_rd;
      end
      scan_idx <= scan_idx + part_t'(1);
    end else if (cmd.mig_cmp) begin
      acc  <= ({1'b0, pnum} < lim);
      best <= ({1'b0, pnum} < lim) ? prop : h;
    end
    if (cmd.mig_rdb) begin
      lim_a <= pair_val;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.fin_upd) begin
      res_target <= best;
      res_number <= clamp_num(pair_val);
      res_acc    <= 1'b0;
      res_blk    <= 1'b0;
    end else if (cmd.mig_fill) begin
      res_target <= best;
      res_number <= clamp_num(slot);
      res_acc    <= acc;
      res_blk    <= blk;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      target_part <= res_target;
      number      <= res_number;
      accepted    <= res_acc;
      block_done  <= res_blk;
      vertex_out  <= vid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/graph_partition_vote_and_migrate.sv
`timescale 1ns / 1ps
// graph partition vote and migrate
// input channel in_valid/in_stall carries one transaction per item: action,
// home_part, neighbor_part, proposed_part, proposal_num, vertex_id
// output channel out_valid/out_stall returns target_part, number, accepted,
// block_done and vertex_out for finish and migrate items only
// vote and new round items give no result; the block stays idle and is ready
// again on the next cycle
// finish runs a start step, a scan over every entry of the tally bank, then a
// read and write-back of the pair counter memory; no new item is taken until
// its result is loaded into the output register
// migrate runs two reads on the single port of the pair memory, a compare and
// the fill update; no new item is taken until its result is loaded
// in_stall is high while a finish or migrate item is worked on
// results sit in an output register; a new item is taken while a result waits,
// and the next result waits in its final step until the output frees up
// reset clears all tallies, pair counters and fill counts at once, no sweep
module graph_partition_vote_and_migrate import gpvm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ACT_W-1:0] action,
  input  part_t            home_part,
  input  part_t            neighbor_part,
  input  part_t            proposed_part,
  input  num_t             proposal_num,
  input  logic [VID_W-1:0] vertex_id,
  output logic             out_valid,
  input  logic             out_stall,
  output part_t            target_part,
  output num_t             number,
  output logic             accepted,
  output logic             block_done,
  output logic [VID_W-1:0] vertex_out
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  gpvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gpvm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .home_part     (home_part),
    .neighbor_part (neighbor_part),
    .proposed_part (proposed_part),
    .proposal_num  (proposal_num),
    .vertex_id     (vertex_id),
    .out_stall     (out_stall),
    .sts           (sts),
    .out_valid     (out_valid),
    .target_part   (target_part),
    .number        (number),
    .accepted      (accepted),
    .block_done    (block_done),
    .vertex_out    (vertex_out)
  );

  logic       work_take;
  logic       out_blocked;
  logic [3:0] steps;

  assign work_take   = in_valid && !in_stall && (action inside {ACT_FINISH, ACT_MIGRATE});
  assign out_blocked = out_valid && out_stall;
  assign steps       = {cmd.latch, cmd.fin_upd, cmd.mig_fill, cmd.load_out};

`include "graph_partition_vote_and_migrate_macros.svh"

  `GPVM_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_blocked, "result overwritten while stalled")
  `GPVM_ASSERT_NXT(a_busy_after_work, work_take, in_stall, "not busy after finish or migrate")
  `GPVM_ASSERT(a_one_step, $onehot0(steps), "conflicting datapath steps")

endmodule

### tb/sv/graph_partition_vote_and_migrate_checker.sv
`timescale 1ns / 1ps
module graph_partition_vote_and_migrate_checker import gpvm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ACT_W-1:0] action,
  input  part_t            home_part,
  input  part_t            neighbor_part,
  input  part_t            proposed_part,
  input  num_t             proposal_num,
  input  logic [VID_W-1:0] vertex_id,
  input  logic             out_valid,
  input  logic             out_stall,
  input  part_t            target_part,
  input  num_t             number,
  input  logic             accepted,
  input  logic             block_done,
  input  logic [VID_W-1:0] vertex_out,
  output int               fail_count,
  output int               owed_count
);

  typedef struct packed {
    part_t            part;
    num_t             num;
    logic             acc;
    logic             blk;
    logic [VID_W-1:0] vid;
  } outcome_t;

  cnt_t     vote_count [NUM_PARTS];
  cnt_t     swap_count [PAIR_DEPTH];
  cnt_t     fill_level [NUM_PARTS];
  outcome_t owed_q [$];
  int       mismatches = 0;

  assign fail_count = mismatches;

  function automatic cnt_t bump(input cnt_t v);
    return (&v) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic num_t clip(input cnt_t v);
    return (v > cnt_t'(NUM_MAX)) ? NUM_MAX : num_t'(v);
  endfunction

  function automatic void wipe_counts(input bit all_banks);
    for (int p = 0; p < NUM_PARTS; p++) begin
      vote_count[p] = '0;
      if (all_banks) fill_level[p] = '0;
    end
    if (all_banks) begin
      for (int k = 0; k < PAIR_DEPTH; k++) swap_count[k] = '0;
    end
  endfunction

  // updates the partition state for one transaction, returns 1 when a result follows
  function automatic bit partition_step(
    input logic [ACT_W-1:0] act,
    input part_t            hp,
    input part_t            np,
    input part_t            pp,
    input num_t             pn,
    input logic [VID_W-1:0] vid,
    output outcome_t        res
  );
    part_t best;
    cnt_t  top_votes;
    cnt_t  fwd;
    cnt_t  rev;
    cnt_t  lim;
    cnt_t  slot;
    cnt_t  nxt;
    res.part = hp;
    res.num  = '0;
    res.acc  = 1'b0;
    res.blk  = 1'b0;
    res.vid  = vid;
    case (act)
      ACT_VOTE: begin
        vote_count[np] = bump(vote_count[np]);
        return 1'b0;
      end
      ACT_NEW: begin
        wipe_counts(1'b1);
        return 1'b0;
      end
      ACT_FINISH: begin
        best = hp;
        top_votes = vote_count[hp];
        for (int p = 0; p < NUM_PARTS; p++) begin
          if (vote_count[p] > top_votes) begin
            best = part_t'(p);
            top_votes = vote_count[p];
          end
        end
        res.part = best;
        res.num = clip(swap_count[{hp, best}]);
        swap_count[{hp, best}] = bump(swap_count[{hp, best}]);
        wipe_counts(1'b0);
      end
      ACT_MIGRATE: begin
        fwd = swap_count[{hp, pp}];
        rev = swap_count[{pp, hp}];
        lim = (fwd < rev) ? fwd : rev;
        if (cnt_t'(pn) < lim) begin
          res.part = pp;
          res.acc = 1'b1;
        end
        slot = fill_level[res.part];
        res.num = clip(slot);
        if (!(&slot)) begin
          nxt = slot + 1'b1;
          fill_level[res.part] = nxt;
          res.blk = (nxt[BLK_W-1:0] == '0);
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (rst) begin
      wipe_counts(1'b1);
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual part %0d number %0d %s %0d",
                   $time, target_part, number, "vertex", vertex_out);
        end else begin
          want = owed_q.pop_front();
          check_field("target_part", 32'(want.part), 32'(target_part));
          check_field("number", 32'(want.num), 32'(number));
          check_field("accepted", 32'(want.acc), 32'(accepted));
          check_field("block_done", 32'(want.blk), 32'(block_done));
          check_field("vertex_out", 32'(want.vid), 32'(vertex_out));
        end
      end
      if (in_valid && !in_stall) begin
        if (partition_step(action, home_part, neighbor_part, proposed_part,
                           proposal_num, vertex_id, fresh))
          owed_q.insert(owed_q.size(), fresh);
      end
    end
    owed_count <= owed_q.size();
  end

endmodule

### tb/sv/graph_partition_vote_and_migrate_tb.sv
`timescale 1ns / 1ps
module graph_partition_vote_and_migrate_tb;
  import gpvm_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int RUN_LEN      = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    part_t            home;
    part_t            dest;
    num_t             num;
    logic [VID_W-1:0] vid;
  } swap_offer_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [ACT_W-1:0] action;
  part_t            home_part;
  part_t            neighbor_part;
  part_t            proposed_part;
  num_t             proposal_num;
  logic [VID_W-1:0] vertex_id;
  logic             out_valid;
  logic             out_stall;
  part_t            target_part;
  num_t             number;
  logic             accepted;
  logic             block_done;
  logic [VID_W-1:0] vertex_out;

  int checker_fails;
  int results_owed;

  logic [ACT_W-1:0] result_kinds [$];
  part_t            finish_homes [$];
  swap_offer_t      offers [$];
  int               driven = 0;
  int               burst_left = 0;
  int               stall_left = 0;
  int               free_left = 0;
  int               quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  graph_partition_vote_and_migrate dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .home_part     (home_part),
    .neighbor_part (neighbor_part),
    .proposed_part (proposed_part),
    .proposal_num  (proposal_num),
    .vertex_id     (vertex_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .target_part   (target_part),
    .number        (number),
    .accepted      (accepted),
    .block_done    (block_done),
    .vertex_out    (vertex_out)
  );

  graph_partition_vote_and_migrate_checker mon (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .home_part     (home_part),
    .neighbor_part (neighbor_part),
    .proposed_part (proposed_part),
    .proposal_num  (proposal_num),
    .vertex_id     (vertex_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .target_part   (target_part),
    .number        (number),
    .accepted      (accepted),
    .block_done    (block_done),
    .vertex_out    (vertex_out),
    .fail_count    (checker_fails),
    .owed_count    (results_owed)
  );

  // receiver stall pattern: stall runs, short free runs and long free stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = $urandom_range(0, 15);
      free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 12);
      out_stall <= 1'b0;
    end
  end

  // finish results become swap offers for later migrate transactions
  always @(posedge clk) begin
    swap_offer_t offer;
    if (!rst && out_valid && !out_stall && result_kinds.size() != 0) begin
      if (result_kinds.pop_front() == ACT_FINISH) begin
        offer.home = finish_homes.pop_front();
        offer.dest = target_part;
        offer.num  = number;
        offer.vid  = vertex_out;
        offers.insert(offers.size(), offer);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_item(input logic [ACT_W-1:0] act, input int unsigned hp,
                            input int unsigned np, input int unsigned pp,
                            input int unsigned pn, input int unsigned vid);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    home_part     <= part_t'(hp);
    neighbor_part <= part_t'(np);
    proposed_part <= part_t'(pp);
    proposal_num  <= num_t'(pn);
    vertex_id     <= VID_W'(vid);
    do @(posedge clk); while (in_stall);
    driven++;
    burst_left--;
    if (act == ACT_FINISH || act == ACT_MIGRATE)
      result_kinds.insert(result_kinds.size(), act);
    if (act == ACT_FINISH) finish_homes.insert(finish_homes.size(), part_t'(hp));
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic pause_sender();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic drain_results();
    pause_sender();
    while (result_kinds.size() != 0) @(posedge clk);
  endtask

  task automatic drive_vote(input part_t np);
    drive_item(ACT_VOTE, $urandom_range(0, 15), 32'(np), $urandom_range(0, 15),
               $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic drive_noise();
    drive_item(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // vertices of two partitions vote for each other, finish, then try to swap
  task automatic swap_round();
    part_t       pa;
    part_t       pb;
    part_t       hp;
    part_t       want;
    part_t       pp;
    num_t        pn;
    swap_offer_t offer;
    if ($urandom_range(0, 2) == 0)
      drive_item(ACT_NEW, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095));
    pa = part_t'($urandom_range(0, 15));
    pb = ($urandom_range(0, 5) == 0) ? pa : part_t'($urandom_range(0, 15));
    repeat ($urandom_range(2, 8)) begin
      hp = $urandom_range(0, 1) ? pa : pb;
      want = (hp == pa) ? pb : pa;
      repeat ($urandom_range(0, 6))
        drive_vote(($urandom_range(0, 3) != 0) ? want : part_t'($urandom_range(0, 15)));
      drive_item(ACT_FINISH, 32'(hp), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
    drain_results();
    while (offers.size() != 0) begin
      offer = offers.pop_front();
      pp = offer.dest;
      pn = offer.num;
      case ($urandom_range(0, 11))
        0: pp = part_t'($urandom_range(0, 15));
        1: pn = num_t'($urandom_range(0, 4095));
        2: pn = offer.num + 1'b1;
        default: ;
      endcase
      drive_item(ACT_MIGRATE, 32'(offer.home), $urandom_range(0, 15), 32'(pp), 32'(pn),
                 32'(offer.vid));
    end
  endtask

  initial begin
    int base;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_VOTE;
    home_part     <= '0;
    neighbor_part <= '0;
    proposed_part <= '0;
    proposal_num  <= '0;
    vertex_id     <= '0;
    out_stall     <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ties, home kept, refused and accepted swaps, clears
    drive_item(ACT_NEW, 15, 15, 15, 4095, 4095);
    drive_item(ACT_VOTE, 0, 0, 0, 0, 0);
    drive_item(ACT_VOTE, 0, 0, 0, 0, 0);
    drive_item(ACT_VOTE, 0, 15, 0, 0, 0);
    drive_item(ACT_VOTE, 0, 15, 0, 0, 0);
    drive_item(ACT_VOTE, 0, 7, 0, 0, 0);
    drive_item(ACT_FINISH, 7, 0, 15, 4095, 4095);
    drive_item(ACT_VOTE, 15, 5, 15, 4095, 4095);
    drive_item(ACT_VOTE, 15, 9, 15, 4095, 4095);
    drive_item(ACT_FINISH, 5, 0, 0, 0, 0);
    drive_item(ACT_FINISH, 15, 15, 15, 4095, 1);
    drive_item(ACT_MIGRATE, 0, 0, 7, 0, 2);
    drive_item(ACT_VOTE, 0, 7, 0, 0, 0);
    drive_item(ACT_FINISH, 0, 0, 0, 0, 3);
    drive_item(ACT_MIGRATE, 0, 0, 7, 0, 4);
    drive_item(ACT_MIGRATE, 7, 0, 0, 4095, 5);
    drive_item(ACT_MIGRATE, 15, 0, 15, 0, 6);
    drive_item(ACT_MIGRATE, 15, 0, 0, 0, 7);
    drive_item(ACT_VOTE, 0, 3, 0, 0, 0);
    drive_item(ACT_NEW, 0, 0, 0, 0, 0);
    drive_item(ACT_FINISH, 3, 0, 0, 0, 8);
    drive_item(ACT_MIGRATE, 0, 0, 7, 0, 9);

    // repeated counts: tally, pair counter, fill level across block boundaries
    drive_item(ACT_NEW, 0, 0, 0, 0, 0);
    repeat (RUN_LEN) drive_vote(part_t'(15));
    drive_item(ACT_FINISH, 0, 0, 0, 0, 4095);
    repeat (RUN_LEN)
      drive_item(ACT_FINISH, 15, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    drive_item(ACT_MIGRATE, 15, 0, 15, 4095, 4095);
    repeat (RUN_LEN)
      drive_item(ACT_MIGRATE, 15, $urandom_range(0, 15), 15,
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    drive_item(ACT_MIGRATE, 15, 0, 3, 0, 0);
    drive_item(ACT_NEW, 0, 0, 0, 0, 0);
    drain_results();
    offers.delete();

    base = driven;
    while (driven < base + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) drive_noise();
      end else begin
        swap_round();
      end
    end

    pause_sender();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (checker_fails == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
